>>> rtl/core/plldiv_pkg.sv
// ----------------------------------------------------------------------------
// plldiv_pkg
// Constants, widths and types shared by the PLL divider search block.
// ----------------------------------------------------------------------------
package plldiv_pkg;

  localparam int MAX_POST_DIV = 6;
  localparam int D2_SPAN      = 14;
  localparam int D2_COUNT     = D2_SPAN - 1;
  localparam int MIN_PRODUCT  = 20;
  localparam int DIV_STEPS    = 8;

  localparam int TARGET_W = 19;
  localparam int REF_W    = 17;
  localparam int MUL_W    = 8;
  localparam int CLK_W    = 21;
  localparam int ERR_W    = CLK_W;
  localparam int POST_W   = 3;
  localparam int REFDIV_W = 5;

  localparam logic [REF_W-1:0] REF_RESET = 17'd27000;

  localparam int D2_MAX   = MAX_POST_DIV + D2_SPAN - 1;
  localparam int PROD_MAX = MAX_POST_DIV * D2_MAX;
  localparam int D1_W     = $clog2(MAX_POST_DIV + 1);
  localparam int D2_W     = $clog2(D2_MAX + 1);
  localparam int PROD_W   = $clog2(PROD_MAX + 1);

  localparam int NUM_W       = TARGET_W + PROD_W + 1;
  localparam int P_W         = MUL_W + REF_W;
  localparam int RECIP_SHIFT = P_W + PROD_W;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam int Q_W         = P_W + RECIP_W;

  localparam int NUM_CELLS = (MAX_POST_DIV - 1) * D2_COUNT;
  localparam int EVAL_LAST = DIV_STEPS + 2;

  typedef struct packed {
    logic                valid;
    logic [TARGET_W-1:0] target;
  } req_t;

  typedef struct packed {
    logic              have;
    logic [D1_W-1:0]   d1;
    logic [D2_W-1:0]   d2;
    logic [MUL_W-1:0]  mul;
    logic [CLK_W-1:0]  clk;
    logic [ERR_W-1:0]  err;
    logic [PROD_W-1:0] prod;
  } best_t;

  typedef struct packed {
    logic [D1_W-1:0]    d1;
    logic [D2_W-1:0]    d2;
    logic [PROD_W-1:0]  prod;
    logic [RECIP_W-1:0] recip;
  } pair_t;

endpackage

>>> rtl/core/plldiv_req_if.sv
// ----------------------------------------------------------------------------
// plldiv_req_if
// Request channel: target pixel clock in kHz.
// ----------------------------------------------------------------------------
interface plldiv_req_if import plldiv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_khz;

  modport source (output valid, output target_khz, input ready);
  modport sink   (input valid, input target_khz, output ready);
endinterface

>>> rtl/core/plldiv_rsp_if.sv
// ----------------------------------------------------------------------------
// plldiv_rsp_if
// Result channel: chosen dividers, multiplier and achieved clock.
// ----------------------------------------------------------------------------
interface plldiv_rsp_if import plldiv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POST_W-1:0]   post_div;
  logic [MUL_W-1:0]    fb_mul;
  logic [REFDIV_W-1:0] ref_div;
  logic [CLK_W-1:0]    achieved_khz;
  logic                found;

  modport source (output valid, output post_div, output fb_mul, output ref_div,
                  output achieved_khz, output found, input ready);
  modport sink   (input valid, input post_div, input fb_mul, input ref_div,
                  input achieved_khz, input found, output ready);
endinterface

>>> rtl/core/plldiv_cell.sv
// ----------------------------------------------------------------------------
// plldiv_cell
// One divider pair: ceil divide by ref, achieved clock by reciprocal,
// then merge with the best set handed on by the previous cell.
// ----------------------------------------------------------------------------
module plldiv_cell import plldiv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [REF_W-1:0] ref_khz_i,
  input  pair_t            pair_i,
  input  req_t             req_i,
  output req_t             req_o,
  input  best_t            best_i,
  output logic             best_valid_o,
  output best_t            best_o
);

  logic                v_q   [EVAL_LAST+1];
  logic [TARGET_W-1:0] tgt_q [EVAL_LAST+1];
  logic                ok_q  [EVAL_LAST+1];
  logic [NUM_W-1:0]    rem_q [DIV_STEPS+1];
  logic [MUL_W-1:0]    quo_q [DIV_STEPS+1];
  logic [P_W-1:0]      p_q;
  logic [MUL_W-1:0]    mul_q;
  logic [MUL_W-1:0]    mul_ev_q;
  logic [CLK_W-1:0]    clk_q;
  logic [Q_W-1:0]      q_full;
  logic [ERR_W-1:0]    err;
  logic                take;
  best_t               best_d;
  best_t               best_q;
  logic                bv_q;

  // valid bits
  for (genvar s = 0; s <= EVAL_LAST; s++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= (s == 0) ? req_i.valid : v_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // stage 0: numerator of the ceil divide
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt_q[0] <= req_i.target;
      ok_q[0]  <= (ref_khz_i != '0) && (pair_i.prod > PROD_W'(MIN_PRODUCT));
      rem_q[0] <= NUM_W'(req_i.target) * NUM_W'(pair_i.prod) + NUM_W'(ref_khz_i)
                  - NUM_W'(1);
      quo_q[0] <= '0;
    end
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
    localparam int BIT = DIV_STEPS - s;
    logic [NUM_W-1:0] dvs;
    logic             ge;
    logic             ovf;
    assign dvs = NUM_W'(ref_khz_i) << BIT;
    assign ge  = rem_q[s-1] >= dvs;
    assign ovf = (s == 1) && (rem_q[s-1] >= (NUM_W'(ref_khz_i) << DIV_STEPS));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tgt_q[s] <= tgt_q[s-1];
        ok_q[s]  <= ok_q[s-1] && !ovf;
        rem_q[s] <= ge ? rem_q[s-1] - dvs : rem_q[s-1];
        quo_q[s] <= {quo_q[s-1][MUL_W-2:0], ge};
      end
    end
  end

  // achieved clock = floor(mul * ref / prod) via exact reciprocal
  assign q_full = Q_W'(p_q) * Q_W'(pair_i.recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt_q[DIV_STEPS+1] <= tgt_q[DIV_STEPS];
      ok_q[DIV_STEPS+1]  <= ok_q[DIV_STEPS];
      p_q                <= P_W'(quo_q[DIV_STEPS]) * P_W'(ref_khz_i);
      mul_q              <= quo_q[DIV_STEPS];
      tgt_q[EVAL_LAST]   <= tgt_q[DIV_STEPS+1];
      ok_q[EVAL_LAST]    <= ok_q[DIV_STEPS+1];
      clk_q              <= q_full[RECIP_SHIFT +: CLK_W];
      mul_ev_q           <= mul_q;
    end
  end

  // merge; mul is a ceiling so clk never falls below target
  assign err  = clk_q - ERR_W'(tgt_q[EVAL_LAST]);
  assign take = ok_q[EVAL_LAST] &&
                (!best_i.have || ((err <= best_i.err) && (pair_i.prod > best_i.prod)));

  always_comb begin
    best_d = best_i;
    if (take) begin
      best_d.have = 1'b1;
      best_d.d1   = pair_i.d1;
      best_d.d2   = pair_i.d2;
      best_d.mul  = mul_ev_q;
      best_d.clk  = clk_q;
      best_d.err  = err;
      best_d.prod = pair_i.prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
    end else if (en_i) begin
      bv_q <= v_q[EVAL_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best_q <= best_d;
    end
  end

  assign req_o        = '{valid: v_q[0], target: tgt_q[0]};
  assign best_valid_o = bv_q;
  assign best_o       = best_q;

endmodule

>>> rtl/core/pll_divider_search.sv
// ----------------------------------------------------------------------------
// pll_divider_search
// PLL divider search over a row of pair cells.
// ----------------------------------------------------------------------------
// Usage: write ref_khz through cfg_we_i/cfg_data_i while idle (reset 27000).
// Each request on req_i carries a target clock in kHz; one result follows
// on rsp_o with post divider, feedback multiplier, reference divider,
// achieved clock and a found flag (all zero when nothing qualifies).
// One cell per divider pair; the request walks the row one cell a cycle
// unless the row holds, while each cell runs an 8-step divide and a
// reciprocal multiply, and the best set so far walks behind it.
// Throughput: one request per cycle unless the row holds; the whole row
// advances together.
// A two-entry output queue lets the row keep moving while one result waits;
// when it is full and rsp_o.ready is low the row holds and req_i.ready drops.
// Reset empties the row and the queue and restores ref_khz.
// ----------------------------------------------------------------------------
module pll_divider_search import plldiv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [REF_W-1:0] cfg_data_i,
  plldiv_req_if.sink       req_i,
  plldiv_rsp_if.source     rsp_o
);

  logic [REF_W-1:0] ref_q;
  logic             en;
  req_t             req_chain  [NUM_CELLS+1];
  best_t            best_chain [NUM_CELLS+1];
  logic             bv_chain   [NUM_CELLS+1];

  best_t            q_ent_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;
  best_t            head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
    end else if (cfg_we_i) begin
      ref_q <= cfg_data_i;
    end
  end

  assign en          = (cnt_q != 2'd2) || rsp_o.ready;
  assign req_i.ready = en;

  assign req_chain[0]  = '{valid: req_i.valid, target: req_i.target_khz};
  assign best_chain[0] = '0;
  assign bv_chain[0]   = 1'b0;

  for (genvar i = 0; i < MAX_POST_DIV - 1; i++) begin : g_d1
    for (genvar j = 0; j < D2_COUNT; j++) begin : g_d2
      localparam int K    = i * D2_COUNT + j;
      localparam int D1   = i + 2;
      localparam int D2   = D1 + 1 + j;
      localparam int PROD = D1 * D2;
      localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PROD) - 64'd1) / 64'(PROD));
      pair_t pair;
      assign pair = '{d1: D1_W'(D1), d2: D2_W'(D2), prod: PROD_W'(PROD), recip: RECIP};

      plldiv_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .en_i         (en),
        .ref_khz_i    (ref_q),
        .pair_i       (pair),
        .req_i        (req_chain[K]),
        .req_o        (req_chain[K+1]),
        .best_i       (best_chain[K]),
        .best_valid_o (bv_chain[K+1]),
        .best_o       (best_chain[K+1])
      );
    end
  end

  // output queue
  assign push = en && bv_chain[NUM_CELLS];
  assign pop  = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_ent_q[wr_q] <= best_chain[NUM_CELLS];
    end
  end

  assign head               = q_ent_q[rd_q];
  assign rsp_o.valid        = cnt_q != 2'd0;
  assign rsp_o.post_div     = POST_W'(head.d1);
  assign rsp_o.fb_mul       = head.mul;
  assign rsp_o.ref_div      = REFDIV_W'(head.d2);
  assign rsp_o.achieved_khz = head.clk;
  assign rsp_o.found        = head.have;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !rsp_o.ready) |-> !push)
    else $error("push into full output queue");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |->
      (rsp_o.post_div == '0 && rsp_o.fb_mul == '0 && rsp_o.ref_div == '0 &&
       rsp_o.achieved_khz == '0))
    else $error("result without found has nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rd_q)))
    else $error("stalled result dropped");

endmodule
